[hw/rtl/motor_feedback_speed_pid_unit_defines.svh]
// Assertion macros for the motor feedback speed PID unit.
`ifndef MOTOR_FEEDBACK_SPEED_PID_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_SPEED_PID_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define MFSP_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define MFSP_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFSP_CHECK(lbl, clk, rst, prop, msg)
`define MFSP_CHECK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/mfsp_pkg.sv]
// Shared widths, constants and types of the motor feedback speed PID unit.
package mfsp_pkg;

   localparam int unsigned ID_W       = 11;
   localparam int unsigned ANGLE_W    = 13;
   localparam int unsigned CUR_W      = 16;
   localparam int unsigned STEP_W     = 14;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned ALPHA_W    = 9;
   localparam int unsigned LIM_W      = 15;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // shared multiplier: 17 x 16 signed, Q8 truncation toward zero, 27-bit accumulator
   localparam int unsigned OPA_W   = 17;
   localparam int unsigned OPB_W   = 16;
   localparam int unsigned PROD_W  = OPA_W + OPB_W;
   localparam int unsigned Q_SHIFT = 8;
   localparam int unsigned ACC_W   = PROD_W - Q_SHIFT + 2;

   localparam logic [ID_W-1:0]       FEEDBACK_ID   = 11'h201;
   localparam logic signed [14:0]    HALF_TURN     = 15'sd4096;
   localparam logic signed [14:0]    FULL_TURN     = 15'sd8192;
   localparam logic [ALPHA_W-1:0]    ALPHA_ONE     = 9'd256;
   localparam logic [PHASE_W-1:0]    PHASE_CONTROL = 3'd0;
   localparam logic [PHASE_W-1:0]    PHASE_RST     = 3'd1;

   localparam logic [GAIN_W-1:0]     TARGET_RST = 16'd0;
   localparam logic [GAIN_W-1:0]     KP_RST     = 16'd2560;
   localparam logic [GAIN_W-1:0]     KI_RST     = 16'd512;
   localparam logic [GAIN_W-1:0]     KD_RST     = 16'd256;
   localparam logic [ALPHA_W-1:0]    ALPHA_RST  = 9'd154;
   localparam logic [LIM_W-1:0]      ILIM_RST   = 15'd1000;
   localparam logic [LIM_W-1:0]      DLIM_RST   = 15'd5000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 3'd0,
      CSR_KP     = 3'd1,
      CSR_KI     = 3'd2,
      CSR_KD     = 3'd3,
      CSR_ALPHA  = 3'd4,
      CSR_ILIM   = 3'd5,
      CSR_DLIM   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic mul_en;    // capture op_a * op_b
      logic acc_load;  // acc = q8(product)
      logic acc_add;   // acc = acc + q8(product)
   } mac_ctrl_type;

endpackage

[hw/rtl/mfsp_mul_acc.sv]
// Shared signed multiplier with Q8 truncation and accumulator.
module mfsp_mul_acc (
   input  logic                                clock,
   input  mfsp_pkg::mac_ctrl_type              ctrl,
   input  logic signed [mfsp_pkg::OPA_W-1:0]   op_a,
   input  logic signed [mfsp_pkg::OPB_W-1:0]   op_b,
   output logic signed [mfsp_pkg::ACC_W-1:0]   acc
);
   import mfsp_pkg::*;

   localparam logic [PROD_W-1:0] Q_BIAS = PROD_W'((1 << Q_SHIFT) - 1);

   logic signed [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [PROD_W-1:0]         prod_biased;
   logic signed [PROD_W-Q_SHIFT-1:0] prod_q;
   logic signed [ACC_W-1:0]          acc_ff, acc_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // divide by 256 toward zero: bias negatives before the arithmetic shift
   assign prod_biased = prod_ff + (prod_ff[PROD_W-1] ? $signed(Q_BIAS) : $signed(PROD_W'(0)));
   assign prod_q      = $signed(prod_biased[PROD_W-1:Q_SHIFT]);

   always_comb begin
      if (ctrl.acc_load) begin
         acc_in = ACC_W'(prod_q);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_q);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_load || ctrl.acc_add) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

[hw/rtl/motor_feedback_speed_pid_unit.sv]
// Motor feedback speed PID unit: encoder unwrap, decimated filter and PID.
// A frame without a control step passes S_IDLE, S_UPDATE and S_DONE; a feedback
//   frame that lands on a control step also runs the filter and PID states first.
// A new frame is taken only in S_IDLE, once the last result has been loaded; the
//   single shared multiplier runs the five filter and PID products one after another.
// Reset (synchronous, active high) loads the register defaults, clears the
//   controller state and sets the frame phase to one.
`include "motor_feedback_speed_pid_unit_defines.svh"

module motor_feedback_speed_pid_unit #(
   parameter int unsigned DECIMATION = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input frames
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [mfsp_pkg::ID_W-1:0]               req_frame_id,
   input  logic [mfsp_pkg::ANGLE_W-1:0]            req_rotor_angle,
   input  logic signed [mfsp_pkg::CUR_W-1:0]       req_measured_current,
   input  logic signed [mfsp_pkg::CUR_W-1:0]       req_commanded_current,
   // results
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [mfsp_pkg::STEP_W-1:0]      rsp_step_speed,
   output logic signed [mfsp_pkg::POS_W-1:0]       rsp_position,
   output logic signed [mfsp_pkg::POS_W-1:0]       rsp_turn_count,
   output logic signed [mfsp_pkg::CUR_W-1:0]       rsp_current_error,
   output logic                                    rsp_drive_valid,
   output logic signed [mfsp_pkg::CUR_W-1:0]       rsp_drive_command,
   // configuration writes
   input  logic                                    csr_write,
   input  logic [mfsp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mfsp_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import mfsp_pkg::*;

   localparam logic [PHASE_W-1:0] DECIM_CODE = PHASE_W'(DECIMATION);

   // Sequencer: a control step runs the filter products (alpha*sum, (1-alpha)*prev),
   // then the PID products (P, I, D) through the one shared multiplier.
   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_UPDATE   = 12'b0000_0000_0010,
      S_MUL_A    = 12'b0000_0000_0100,
      S_MUL_B    = 12'b0000_0000_1000,
      S_FILT_SUM = 12'b0000_0001_0000,
      S_PID      = 12'b0000_0010_0000,
      S_MUL_P    = 12'b0000_0100_0000,
      S_MUL_I    = 12'b0000_1000_0000,
      S_MUL_D    = 12'b0001_0000_0000,
      S_SUM_D    = 12'b0010_0000_0000,
      S_CLAMP    = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // configuration registers
   logic signed [GAIN_W-1:0]  target_ff, kp_ff, ki_ff, kd_ff;
   logic [ALPHA_W-1:0]        alpha_ff;
   logic [LIM_W-1:0]          ilim_ff, dlim_ff;

   // latched input frame
   logic [ID_W-1:0]           id_ff;
   logic [ANGLE_W-1:0]        angle_ff;
   logic signed [CUR_W-1:0]   meas_ff, cmd_ff;

   // controller state
   logic [ANGLE_W-1:0]        last_angle_ff;
   logic signed [POS_W-1:0]   turns_ff, pos_ff;
   logic signed [15:0]        speed_sum_ff, filtered_ff, error_accum_ff;
   logic [PHASE_W-1:0]        phase_ff;

   // per-frame work registers
   logic signed [STEP_W-1:0]  step_ff;
   logic signed [CUR_W-1:0]   cerr_ff, drive_ff;
   logic                      dvalid_ff;
   logic signed [16:0]        err_ff, dterm_ff;

   // result register
   logic                      rsp_valid_ff;
   logic signed [STEP_W-1:0]  rsp_step_ff;
   logic signed [POS_W-1:0]   rsp_pos_ff, rsp_turns_ff;
   logic signed [CUR_W-1:0]   rsp_cerr_ff, rsp_drive_ff;
   logic                      rsp_dvalid_ff;

   // ---------------- frame update (unwrap, phase) ----------------
   logic [PHASE_W-1:0]        phase_inc, phase_next;
   logic                      is_feedback, ctrl_step;
   logic signed [14:0]        angle_diff, step_wide;
   logic signed [STEP_W-1:0]  step_new;
   logic signed [POS_W-1:0]   turns_new;

   assign phase_inc   = phase_ff + PHASE_W'(1);
   assign phase_next  = (phase_inc == DECIM_CODE) ? PHASE_CONTROL : phase_inc;
   assign is_feedback = (id_ff == FEEDBACK_ID);
   assign ctrl_step   = is_feedback && (phase_next == PHASE_CONTROL);
   assign angle_diff  = $signed({2'b00, angle_ff}) - $signed({2'b00, last_angle_ff});

   // more than half a turn either way means the encoder wrapped
   always_comb begin
      if (angle_diff > HALF_TURN) begin
         step_wide = angle_diff - FULL_TURN;
         turns_new = turns_ff - POS_W'(1);
      end else if (angle_diff < -HALF_TURN) begin
         step_wide = angle_diff + FULL_TURN;
         turns_new = turns_ff + POS_W'(1);
      end else begin
         step_wide = angle_diff;
         turns_new = turns_ff;
      end
   end
   assign step_new = step_wide[STEP_W-1:0];

   // ---------------- shared multiplier ----------------
   mac_ctrl_type              mac_ctrl;
   logic signed [OPA_W-1:0]   op_a;
   logic signed [OPB_W-1:0]   op_b;
   logic signed [ACC_W-1:0]   mac_acc;
   logic [ALPHA_W-1:0]        alpha_sat;

   assign alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   always_comb begin
      mac_ctrl = '0;
      op_a     = OPA_W'(speed_sum_ff);
      op_b     = $signed(OPB_W'(alpha_sat));
      case (state_ff)
         S_MUL_A: begin
            mac_ctrl.mul_en = 1'b1;
         end
         S_MUL_B: begin
            mac_ctrl.mul_en   = 1'b1;
            mac_ctrl.acc_load = 1'b1;
            op_a = OPA_W'(filtered_ff);
            op_b = $signed(OPB_W'(ALPHA_ONE - alpha_sat));
         end
         S_FILT_SUM: begin
            mac_ctrl.acc_add = 1'b1;
         end
         S_MUL_P: begin
            mac_ctrl.mul_en = 1'b1;
            op_a = err_ff;
            op_b = kp_ff;
         end
         S_MUL_I: begin
            mac_ctrl.mul_en   = 1'b1;
            mac_ctrl.acc_load = 1'b1;
            op_a = OPA_W'(error_accum_ff);
            op_b = ki_ff;
         end
         S_MUL_D: begin
            mac_ctrl.mul_en  = 1'b1;
            mac_ctrl.acc_add = 1'b1;
            op_a = dterm_ff;
            op_b = kd_ff;
         end
         // D product is added into the accumulator in S_SUM_D, the state after its multiply
         S_SUM_D: begin
            mac_ctrl.acc_add = 1'b1;
         end
         default: begin
         end
      endcase
   end

   mfsp_mul_acc u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (mac_acc)
   );

   // ---------------- PID step (filtered speed is in the accumulator) ----------------
   logic signed [16:0]        filt_new, err_new, dterm_new;
   logic signed [17:0]        integ_sum, ilim_s18, integ_clamped;
   logic signed [ACC_W-1:0]   dlim_s, drive_clamped;

   assign filt_new  = mac_acc[16:0];
   assign err_new   = 17'(target_ff) - filt_new;
   assign dterm_new = filt_new - 17'(filtered_ff);
   assign integ_sum = 18'(error_accum_ff) + 18'(err_new);
   assign ilim_s18  = $signed({3'b000, ilim_ff});
   assign dlim_s    = $signed(ACC_W'(dlim_ff));

   always_comb begin
      if (integ_sum > ilim_s18) begin
         integ_clamped = ilim_s18;
      end else if (integ_sum < -ilim_s18) begin
         integ_clamped = -ilim_s18;
      end else begin
         integ_clamped = integ_sum;
      end
   end

   always_comb begin
      if (mac_acc > dlim_s) begin
         drive_clamped = dlim_s;
      end else if (mac_acc < -dlim_s) begin
         drive_clamped = -dlim_s;
      end else begin
         drive_clamped = mac_acc;
      end
   end

   // ---------------- sequencer ----------------
   logic rsp_load;

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_UPDATE;
         S_UPDATE:   state_in = ctrl_step ? S_MUL_A : S_DONE;
         S_MUL_A:    state_in = S_MUL_B;
         S_MUL_B:    state_in = S_FILT_SUM;
         S_FILT_SUM: state_in = S_PID;
         S_PID:      state_in = S_MUL_P;
         S_MUL_P:    state_in = S_MUL_I;
         S_MUL_I:    state_in = S_MUL_D;
         S_MUL_D:    state_in = S_SUM_D;
         S_SUM_D:    state_in = S_CLAMP;
         S_CLAMP:    state_in = S_DONE;
         S_DONE:     if (rsp_load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         target_ff      <= TARGET_RST;
         kp_ff          <= KP_RST;
         ki_ff          <= KI_RST;
         kd_ff          <= KD_RST;
         alpha_ff       <= ALPHA_RST;
         ilim_ff        <= ILIM_RST;
         dlim_ff        <= DLIM_RST;
         last_angle_ff  <= '0;
         turns_ff       <= '0;
         pos_ff         <= '0;
         speed_sum_ff   <= '0;
         filtered_ff    <= '0;
         error_accum_ff <= '0;
         phase_ff       <= PHASE_RST;
      end else begin
         state_ff <= state_in;

         if (csr_write) begin
            case (csr_index)
               CSR_TARGET: target_ff <= csr_wdata;
               CSR_KP:     kp_ff     <= csr_wdata;
               CSR_KI:     ki_ff     <= csr_wdata;
               CSR_KD:     kd_ff     <= csr_wdata;
               CSR_ALPHA:  alpha_ff  <= csr_wdata[ALPHA_W-1:0];
               CSR_ILIM:   ilim_ff   <= csr_wdata[LIM_W-1:0];
               CSR_DLIM:   dlim_ff   <= csr_wdata[LIM_W-1:0];
               default: begin
               end
            endcase
         end

         if (state_ff == S_UPDATE) begin
            phase_ff <= phase_next;
            if (is_feedback) begin
               last_angle_ff <= angle_ff;
               turns_ff      <= turns_new;
               pos_ff        <= pos_ff + POS_W'(step_new);
               speed_sum_ff  <= speed_sum_ff + 16'(step_new);
            end
         end

         if (state_ff == S_PID) begin
            filtered_ff    <= filt_new[15:0];
            error_accum_ff <= integ_clamped[15:0];
            speed_sum_ff   <= '0;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         id_ff    <= req_frame_id;
         angle_ff <= req_rotor_angle;
         meas_ff  <= req_measured_current;
         cmd_ff   <= req_commanded_current;
      end
      if (state_ff == S_UPDATE) begin
         step_ff   <= is_feedback ? step_new : '0;
         cerr_ff   <= is_feedback ? (meas_ff - cmd_ff) : '0;
         dvalid_ff <= 1'b0;
         drive_ff  <= '0;
      end
      if (state_ff == S_PID) begin
         err_ff   <= err_new;
         dterm_ff <= dterm_new;
      end
      if (state_ff == S_CLAMP) begin
         dvalid_ff <= 1'b1;
         drive_ff  <= drive_clamped[CUR_W-1:0];
      end
      if (rsp_load) begin
         rsp_step_ff   <= step_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_turns_ff  <= turns_ff;
         rsp_cerr_ff   <= cerr_ff;
         rsp_dvalid_ff <= dvalid_ff;
         rsp_drive_ff  <= drive_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_speed    = rsp_step_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_turn_count    = rsp_turns_ff;
   assign rsp_current_error = rsp_cerr_ff;
   assign rsp_drive_valid   = rsp_dvalid_ff;
   assign rsp_drive_command = rsp_drive_ff;

   // ---------------- assertions ----------------
   `MFSP_CHECK_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE) && !rsp_valid_ff, "reset left sequencer busy or result pending")
   `MFSP_CHECK(a_drive_on_control, clock, reset, rsp_load && dvalid_ff |-> phase_ff == PHASE_CONTROL, "drive command outside a control phase")
   `MFSP_CHECK(a_integ_bounded, clock, reset, (state_ff == S_MUL_P) |-> (18'(error_accum_ff) <= ilim_s18) && (18'(error_accum_ff) >= -ilim_s18), "error accumulator beyond its limit")
   `MFSP_CHECK(a_drive_bounded, clock, reset, rsp_load && dvalid_ff |-> (ACC_W'(drive_ff) <= dlim_s) && (ACC_W'(drive_ff) >= -dlim_s), "drive command beyond its limit")

endmodule
